@@ rtl/core/smx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the spiral matrix scan block.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] element;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic               last;
  } out_item_t;

  // per-operation control carried from front to back
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [3:0] row;
    logic [3:0] col;
  } op_meta_t;

endpackage
`default_nettype wire

@@ rtl/core/spiral_matrix_scan_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spiral_matrix_scan_top
// Matrix store with row-major loading and clockwise spiral read-out.
// ----------------------------------------------------------------------------
// One transaction is taken per clock; busy stays low in normal use because
// the back end drains one queued op every cycle. A load transaction writes
// the store and produces no result. An emit transaction produces its result
// on out_data with out_valid high for one cycle, after it has passed through
// the queue and the registered store read.
// The receiver cannot stall, so results must be taken as they appear.
// Any write to a size register restarts the load and spiral positions.
module spiral_matrix_scan_top
  import smx_pkg::*;
#(
  parameter int MAX_DIM    = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = $bits(op_meta_t) + AW + DATA_WIDTH;

  logic                  accept;
  logic                  f_push;
  op_meta_t              f_meta;
  logic [AW-1:0]         f_addr;
  logic [DATA_WIDTH-1:0] f_wdata;
  logic                  q_full, q_empty;
  logic [QW-1:0]         q_out;
  op_meta_t              b_meta;
  logic [AW-1:0]         b_addr;
  logic [DATA_WIDTH-1:0] b_wdata;

  assign accept = start && !busy;
  assign busy   = q_full;

  smx_front #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op_push   (f_push),
    .op_meta   (f_meta),
    .op_addr   (f_addr),
    .op_wdata  (f_wdata)
  );

  smx_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_meta, f_addr, f_wdata}),
    .pop       (!q_empty),
    .full      (q_full),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  assign {b_meta, b_addr, b_wdata} = q_out;

  smx_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!q_empty),
    .op_meta   (b_meta),
    .op_addr   (b_addr),
    .op_wdata  (b_wdata),
    .res_valid (out_valid),
    .res_item  (out_data)
  );
endmodule
`default_nettype wire

@@ rtl/core/smx_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         addr,
  input  wire logic [WIDTH-1:0]      wdata,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ rtl/core/smx_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_front
// Accepts transactions, keeps the load and spiral positions, issues ops.
// ----------------------------------------------------------------------------
module smx_front
  import smx_pkg::*;
#(
  parameter int MAX_DIM    = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire in_item_t              item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                       op_push,
  output op_meta_t                   op_meta,
  output logic [AW-1:0]              op_addr,
  output logic [DATA_WIDTH-1:0]      op_wdata
);
  localparam int RW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int EW    = DW + 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] ncols_r, nrows_r;
  logic [RW-1:0] load_row_r, load_col_r, load_row_nxt, load_col_nxt;
  logic [RW-1:0] ring_r, ring_nxt;
  logic [1:0]    side_r, side_nxt;
  logic [RW-1:0] scan_row_r, scan_col_r, scan_row_nxt, scan_col_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [DW-1:0] cfg_dim;
  logic [EW-1:0] top, bottom, right, srow, scol;
  logic [CW-1:0] total, cnt_inc;
  logic          is_last;
  logic          is_emit;

  // size registers take 0 as 1 and clip at the array dimension
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_dim = DW'(1);
    end else if (32'(cfg_wdata) > MAX_DIM) begin
      cfg_dim = DW'(MAX_DIM);
    end else begin
      cfg_dim = DW'(cfg_wdata);
    end
  end

  assign is_emit = (item.kind == KIND_EMIT);
  assign total   = CW'(nrows_r) * CW'(ncols_r);
  assign cnt_inc = cnt_r + CW'(1);
  assign is_last = (cnt_inc >= total);

  assign top    = EW'(ring_r);
  assign bottom = EW'(nrows_r) - EW'(1) - EW'(ring_r);
  assign right  = EW'(ncols_r) - EW'(1) - EW'(ring_r);
  assign srow   = EW'(scan_row_r);
  assign scol   = EW'(scan_col_r);

  // row-major load position
  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r + RW'(1);
    if (EW'(load_col_r) + EW'(1) >= EW'(ncols_r)) begin
      load_col_nxt = '0;
      if (EW'(load_row_r) + EW'(1) >= EW'(nrows_r)) begin
        load_row_nxt = '0;
      end else begin
        load_row_nxt = load_row_r + RW'(1);
      end
    end
  end

  // clockwise walk: step along the side, turn the corner, drop a ring or restart after the last
  always_comb begin
    ring_nxt     = ring_r;
    side_nxt     = side_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    cnt_nxt      = cnt_inc;
    if (is_last) begin
      ring_nxt     = '0;
      side_nxt     = SIDE_TOP;
      scan_row_nxt = '0;
      scan_col_nxt = '0;
      cnt_nxt      = '0;
    end else begin
      unique case (side_r)
        SIDE_TOP: begin
          if (scol < right) begin
            scan_col_nxt = scan_col_r + RW'(1);
          end else if (bottom > top) begin
            side_nxt     = SIDE_RIGHT;
            scan_row_nxt = RW'(top + EW'(1));
            scan_col_nxt = RW'(right);
          end else begin
            ring_nxt     = ring_r + RW'(1);
            side_nxt     = SIDE_TOP;
            scan_row_nxt = ring_r + RW'(1);
            scan_col_nxt = ring_r + RW'(1);
          end
        end
        SIDE_RIGHT: begin
          if (srow < bottom) begin
            scan_row_nxt = scan_row_r + RW'(1);
          end else if (right > top) begin
            side_nxt     = SIDE_BOTTOM;
            scan_row_nxt = RW'(bottom);
            scan_col_nxt = RW'(right - EW'(1));
          end else begin
            ring_nxt     = ring_r + RW'(1);
            side_nxt     = SIDE_TOP;
            scan_row_nxt = ring_r + RW'(1);
            scan_col_nxt = ring_r + RW'(1);
          end
        end
        SIDE_BOTTOM: begin
          if (scol > top) begin
            scan_col_nxt = scan_col_r - RW'(1);
          end else if (bottom > top + EW'(1)) begin
            side_nxt     = SIDE_LEFT;
            scan_row_nxt = RW'(bottom - EW'(1));
            scan_col_nxt = RW'(top);
          end else begin
            ring_nxt     = ring_r + RW'(1);
            side_nxt     = SIDE_TOP;
            scan_row_nxt = ring_r + RW'(1);
            scan_col_nxt = ring_r + RW'(1);
          end
        end
        SIDE_LEFT: begin
          if (srow > top + EW'(1)) begin
            scan_row_nxt = scan_row_r - RW'(1);
          end else begin
            ring_nxt     = ring_r + RW'(1);
            side_nxt     = SIDE_TOP;
            scan_row_nxt = ring_r + RW'(1);
            scan_col_nxt = ring_r + RW'(1);
          end
        end
        default: begin
          side_nxt = side_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncols_r    <= DW'(1);
      nrows_r    <= DW'(1);
      load_row_r <= '0;
      load_col_r <= '0;
      ring_r     <= '0;
      side_r     <= SIDE_TOP;
      scan_row_r <= '0;
      scan_col_r <= '0;
      cnt_r      <= '0;
    end else if (cfg_we) begin
      // a size change restarts both positions, stored data is kept
      unique case (cfg_index)
        REG_NUM_COLUMNS: ncols_r <= cfg_dim;
        REG_NUM_ROWS:    nrows_r <= cfg_dim;
        default:         ncols_r <= ncols_r;
      endcase
      load_row_r <= '0;
      load_col_r <= '0;
      ring_r     <= '0;
      side_r     <= SIDE_TOP;
      scan_row_r <= '0;
      scan_col_r <= '0;
      cnt_r      <= '0;
    end else if (accept) begin
      if (is_emit) begin
        ring_r     <= ring_nxt;
        side_r     <= side_nxt;
        scan_row_r <= scan_row_nxt;
        scan_col_r <= scan_col_nxt;
        cnt_r      <= cnt_nxt;
      end else begin
        load_row_r <= load_row_nxt;
        load_col_r <= load_col_nxt;
      end
    end
  end

  always_comb begin
    op_push       = accept;
    op_meta.emit  = is_emit;
    op_meta.last  = is_last;
    op_meta.row   = 4'(scan_row_r);
    op_meta.col   = 4'(scan_col_r);
    op_wdata      = DATA_WIDTH'(item.element);
    if (is_emit) begin
      op_addr = AW'(AW'(scan_row_r) * AW'(MAX_DIM) + AW'(scan_col_r));
    end else begin
      op_addr = AW'(AW'(load_row_r) * AW'(MAX_DIM) + AW'(load_col_r));
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/smx_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_queue
// Two-entry queue between the front and back halves.
// ----------------------------------------------------------------------------
module smx_queue #(
  parameter int WIDTH = 48
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic [WIDTH-1:0]      pop_data
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/smx_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_back
// Runs queued ops against the matrix store and drives the result strobe.
// ----------------------------------------------------------------------------
module smx_back
  import smx_pkg::*;
#(
  parameter int MAX_DIM    = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  op_valid,
  input  wire op_meta_t              op_meta,
  input  wire logic [AW-1:0]         op_addr,
  input  wire logic [DATA_WIDTH-1:0] op_wdata,
  output logic                       res_valid,
  output out_item_t                  res_item
);
  logic                  rd_valid_r;
  op_meta_t              meta_r;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  ram_we, ram_re;

  assign ram_we = op_valid && !op_meta.emit;
  assign ram_re = op_valid && op_meta.emit;

  smx_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (op_addr),
    .wdata (op_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ram_re) begin
      meta_r <= op_meta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= ram_re;
    end
  end

  always_comb begin
    res_valid          = rd_valid_r;
    res_item.out_value = 32'($signed(rdata));
    res_item.out_row   = meta_r.row;
    res_item.out_col   = meta_r.col;
    res_item.last      = meta_r.last;
  end
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spiral_matrix_scan_top. Loads matrices row-major,
// reads them back in clockwise spiral order and checks value, position and
// last flag of every result against an in-bench prediction of the block.
// ----------------------------------------------------------------------------
module testbench;
  import smx_pkg::*;

  localparam int          MAX_DIM        = 16;
  localparam time         CLK_PERIOD     = 10ns;
  localparam int          DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED    = 60;

  typedef struct {
    out_item_t       result;
    longint unsigned taken_at;
  } pending_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predicted block state
  logic signed [31:0] matrix [MAX_DIM][MAX_DIM];
  bit                 written [MAX_DIM][MAX_DIM];
  int unsigned        num_cols;
  int unsigned        num_rows;
  int unsigned        load_r;
  int unsigned        load_c;
  int unsigned        ring;
  logic [1:0]         side;
  int unsigned        scan_r;
  int unsigned        scan_c;
  int unsigned        emitted;

  pending_result_t spiral_expected[$];

  longint unsigned cycle_count  = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     idle_pct     = 0;
  int unsigned     error_count  = 0;
  int unsigned     items_sent   = 0;
  int unsigned     loads_sent   = 0;
  int unsigned     results_seen = 0;
  int unsigned     spirals_done = 0;
  int unsigned     size_writes  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  spiral_matrix_scan_top #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(32)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] code);
    if (code == 0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return 32'(code);
  endfunction

  function automatic void restart_positions();
    load_r  = 0;
    load_c  = 0;
    ring    = 0;
    side    = SIDE_TOP;
    scan_r  = 0;
    scan_c  = 0;
    emitted = 0;
  endfunction

  function automatic void enter_next_ring();
    ring++;
    side   = SIDE_TOP;
    scan_r = ring;
    scan_c = ring;
  endfunction

  function automatic void store_element(input logic signed [31:0] element);
    matrix[load_r][load_c]  = element;
    written[load_r][load_c] = 1'b1;
    load_c++;
    if (load_c >= num_cols) begin
      load_c = 0;
      load_r++;
      if (load_r >= num_rows) load_r = 0;
    end
  endfunction

  function automatic void step_spiral();
    int unsigned top;
    int unsigned left;
    int unsigned bottom;
    int unsigned right;
    top    = ring;
    left   = ring;
    bottom = num_rows - 1 - ring;
    right  = num_cols - 1 - ring;
    case (side)
      SIDE_TOP: begin
        if (scan_c < right) scan_c++;
        else if (bottom > top) begin
          side   = SIDE_RIGHT;
          scan_r = top + 1;
          scan_c = right;
        end else enter_next_ring();
      end
      SIDE_RIGHT: begin
        if (scan_r < bottom) scan_r++;
        else if (right > left) begin
          side   = SIDE_BOTTOM;
          scan_r = bottom;
          scan_c = right - 1;
        end else enter_next_ring();
      end
      SIDE_BOTTOM: begin
        if (scan_c > left) scan_c--;
        else if (bottom > top + 1) begin
          side   = SIDE_LEFT;
          scan_r = bottom - 1;
          scan_c = left;
        end else enter_next_ring();
      end
      default: begin
        if (scan_r > top + 1) scan_r--;
        else enter_next_ring();
      end
    endcase
  endfunction

  function automatic out_item_t next_spiral_result();
    out_item_t r;
    r.out_value = matrix[scan_r][scan_c];
    r.out_row   = 4'(scan_r);
    r.out_col   = 4'(scan_c);
    emitted++;
    r.last = (emitted >= num_rows * num_cols);
    if (r.last) begin
      ring    = 0;
      side    = SIDE_TOP;
      scan_r  = 0;
      scan_c  = 0;
      emitted = 0;
    end else begin
      step_spiral();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic kind, input logic signed [31:0] element);
    in_item_t item;
    pending_result_t pend;
    item.kind    = kind;
    item.element = element;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start           = 1'b0;
      in_data.kind    = 1'($urandom_range(1));
      in_data.element = $urandom;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    start   = 1'b1;
    in_data = item;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (kind == KIND_EMIT) begin
      pend.result   = next_spiral_result();
      pend.taken_at = cycle_count;
      spiral_expected.push_back(pend);
    end else begin
      store_element(element);
      loads_sent++;
    end
  endtask

  // size registers are only touched once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] code);
    @(negedge clk);
    start = 1'b0;
    while (spiral_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = code;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_NUM_COLUMNS) num_cols = clamp_size(code);
    else num_rows = clamp_size(code);
    restart_positions();
    size_writes++;
  endtask

  function automatic logic signed [31:0] random_element();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // mostly small matrices, now and then any code the register can hold
  function automatic logic [CFG_DATA_W-1:0] random_size_code();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 14) return CFG_DATA_W'($urandom_range(1, 4));
    if (pick < 18) return CFG_DATA_W'($urandom_range(5, 8));
    return CFG_DATA_W'($urandom_range(31));
  endfunction

  task automatic load_and_scan_matrix(input int unsigned passes);
    int unsigned area;
    area = num_rows * num_cols;
    repeat (area) send_item(KIND_LOAD, random_element());
    repeat (passes * area) send_item(KIND_EMIT, $urandom);
  endtask

  // loose mix of loads and emits; an emit that would hit a never-loaded
  // entry is turned into a load
  task automatic mixed_traffic(input int unsigned count);
    logic kind;
    repeat (count) begin
      kind = $urandom_range(1) ? KIND_EMIT : KIND_LOAD;
      if (kind == KIND_EMIT && !written[scan_r][scan_c]) kind = KIND_LOAD;
      send_item(kind, random_element());
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
               $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    pending_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_data.last) spirals_done++;
      // an emit taken on this very edge cannot have its result out yet
      if (spiral_expected.size() == 0 || spiral_expected[0].taken_at >= cycle_count) begin
        report_mismatch("result with no emit outstanding", out_data.out_value, '0);
      end else begin
        want = spiral_expected.pop_front();
        if (out_data.out_value !== want.result.out_value)
          report_mismatch("out_value", out_data.out_value, want.result.out_value);
        if (out_data.out_row !== want.result.out_row)
          report_mismatch("out_row", 32'(out_data.out_row), 32'(want.result.out_row));
        if (out_data.out_col !== want.result.out_col)
          report_mismatch("out_col", 32'(out_data.out_col), 32'(want.result.out_col));
        if (out_data.last !== want.result.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.result.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && ((start && !busy) || out_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("spiral_matrix_scan_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset size is 1x1: every emit is the last and the spiral restarts at once
  task automatic test_single_element();
    send_item(KIND_LOAD, 32'sh8000_0000);
    send_item(KIND_EMIT, 32'sd0);
    send_item(KIND_LOAD, 32'sh7fff_ffff);
    send_item(KIND_EMIT, -32'sd1);
    send_item(KIND_EMIT, 32'sh5555_5555);
  endtask

  // one full ring of a 2x3 matrix, a size write part way through the spiral
  // restarts it while the stored values stay
  task automatic test_ring_and_restart();
    write_reg(REG_NUM_COLUMNS, 5'd3);
    write_reg(REG_NUM_ROWS, 5'd2);
    send_item(KIND_LOAD, 32'sh5555_5555);
    send_item(KIND_LOAD, 32'shaaaa_aaaa);
    send_item(KIND_LOAD, -32'sd1);
    send_item(KIND_LOAD, 32'sd0);
    send_item(KIND_LOAD, 32'sh8000_0000);
    send_item(KIND_LOAD, 32'sh7fff_ffff);
    repeat (3) send_item(KIND_EMIT, $urandom);
    write_reg(REG_NUM_ROWS, 5'd2);
    repeat (6) send_item(KIND_EMIT, $urandom);
  endtask

  // zero reads as one, anything above the maximum reads as the maximum
  task automatic test_size_clamping();
    write_reg(REG_NUM_COLUMNS, 5'd0);
    repeat (2) send_item(KIND_EMIT, $urandom);
    write_reg(REG_NUM_COLUMNS, 5'd31);
    write_reg(REG_NUM_ROWS, 5'd0);
    repeat (3) send_item(KIND_EMIT, $urandom);
  endtask

  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned quota);
    int unsigned stop_at;
    idle_pct = sender_idle;
    stop_at  = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(1)) begin
        write_reg(REG_NUM_COLUMNS, random_size_code());
        write_reg(REG_NUM_ROWS, random_size_code());
      end else begin
        write_reg(REG_NUM_ROWS, random_size_code());
        write_reg(REG_NUM_COLUMNS, random_size_code());
      end
      if ($urandom_range(9) < 7) load_and_scan_matrix($urandom_range(1, 2));
      else mixed_traffic($urandom_range(4, 40));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    num_cols  = 1;
    num_rows  = 1;
    restart_positions();
    foreach (written[r, c]) written[r][c] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 22;
    test_single_element();
    test_ring_and_restart();
    test_size_clamping();
    test_random_traffic(22, 525);
    test_random_traffic(63, 525);
    test_random_traffic(0, 525);

    @(negedge clk);
    start = 1'b0;
    while (spiral_expected.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d transactions (%0d loads), checked %0d spiral results",
             items_sent, loads_sent, results_seen);
    $display("%0d complete spirals over %0d size register writes, %0d mismatches",
             spirals_done, size_writes, error_count);
    if (error_count == 0) begin
      $display("spiral_matrix_scan_top regression: pass");
    end else begin
      $display("spiral_matrix_scan_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/smx_pkg.sv
rtl/core/smx_ram.sv
rtl/core/smx_front.sv
rtl/core/smx_queue.sv
rtl/core/smx_back.sv
rtl/core/spiral_matrix_scan_top.sv
bench/testbench.sv
